// ----- src/rlm_pkg.sv -----
// package: types, codes and constants shared by the lock manager modules
`timescale 1ns / 1ps
package rlm_pkg;

  localparam int NUM_TX          = 16;
  localparam int TX_W            = 4;
  localparam int KEY_W           = 32;
  localparam int MAX_RESULTS     = 16;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int NUM_ROWS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_BEGIN   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_HELD      = 3'd1,
    ST_WAITING   = 3'd2,
    ST_DEADLOCK  = 3'd3,
    ST_SHRINKING = 3'd4,
    ST_FULL      = 3'd5,
    ST_RELEASED  = 3'd6,
    ST_BEGUN     = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [TX_W-1:0]  tx_id;
    logic [KEY_W-1:0] row_key;
    logic             lock_exclusive;
  } in_item_t;

  typedef struct packed {
    logic [TX_W-1:0]  result_tx;
    logic [KEY_W-1:0] result_key;
    logic [2:0]       status;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    logic            granted;
    logic            excl;
    logic [TX_W-1:0] tx;
  } slot_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BEGIN,
    OP_EMIT_IN,
    OP_REL_START,
    OP_LK_START,
    OP_LK_NEXT,
    OP_LK_HIT,
    OP_LK_ALLOC,
    OP_ACQ_GRANT,
    OP_ACQ_BLOCK,
    OP_ACQ_DEAD,
    OP_ACQ_WAIT,
    OP_RL_ROW,
    OP_RC_LOAD,
    OP_RC_NEXT_ROW,
    OP_RC_END_ROW,
    OP_RC_GRANT,
    OP_RC_BLOCK,
    OP_RC_SKIP,
    OP_RC_DEAD,
    OP_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  shrink_hit;
    logic  wait_hit;
    logic  tag_hit;
    logic  row_valid;
    logic  row_last;
    logic  alloc_ok;
    logic  held;
    logic  q_full;
    logic  acq_blk_zero;
    logic  slot_end;
    logic  slot_granted;
    logic  rc_blk_zero;
    logic  cap;
    logic  cyc_busy;
    logic  cyc_done;
    logic  cyc_found;
    logic  emit_ok;
    logic  flush_ok;
  } dp_stat_t;

endpackage

// ----- src/rlm_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module rlm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/rlm_dp.sv -----
// datapath: row tables, request queues, waits-for matrix, cycle search, result registers
`timescale 1ns / 1ps
module rlm_dp #(
  parameter int NUM_ROWS    = rlm_pkg::NUM_ROWS_DEF,
  parameter int QUEUE_DEPTH = rlm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rlm_pkg::in_item_t   in_data,
  input  rlm_pkg::dp_cmd_t    cmd,
  output rlm_pkg::dp_stat_t   stat,
  input  logic                out_ready,
  output logic                out_valid,
  output rlm_pkg::out_item_t  out_data
);
  import rlm_pkg::*;

  localparam int RW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int IW    = $clog2(QUEUE_DEPTH + 1);
  localparam int QBITS = QUEUE_DEPTH * $bits(slot_t);

  typedef slot_t [QUEUE_DEPTH-1:0] queue_t;

  in_item_t          item_r;
  logic [RW-1:0]     row_r, sel_r, free_r;
  logic              free_found_r;
  logic [NUM_ROWS-1:0] row_valid_r;
  logic [NUM_TX-1:0] shrink_r;
  logic [NUM_TX-1:0] wm_r [NUM_TX];
  queue_t            q_r;
  logic [KEY_W-1:0]  tag_r;
  logic [IW-1:0]     idx_r;
  logic [CNT_W-1:0]  cnt_r;
  out_item_t         pend_r, out_r;
  logic              pend_v_r, out_v_r;
  logic              cyc_busy_r, cyc_prune_r, cyc_done_r, cyc_found_r;
  logic [NUM_TX-1:0] cyc_s_r;

  logic [KEY_W-1:0]  tag_q;
  logic [QBITS-1:0]  qram_raw;
  queue_t            qram_q, ram_q_eff, q_ins, q_ins_g, rel_q, rm_q, q_wq;
  logic              row_vld_cur, row_last;
  logic [RW-1:0]     alloc_row, row_inc;
  logic              held;
  logic [IW-1:0]     ins_pos, kpos;
  logic              q_full;
  logic [NUM_TX-1:0] acq_blk, rc_blk, reach, keep;
  slot_t             cur;
  logic              slot_end;
  logic              q_we, tag_we;
  logic [RW-1:0]     q_waddr;
  logic              emit_en, out_load;
  out_item_t         emit_item;
  logic              cyc_start;
  logic [TX_W-1:0]   cyc_node;

  assign qram_q      = queue_t'(qram_raw);
  assign row_vld_cur = row_valid_r[row_r];
  assign ram_q_eff   = row_vld_cur ? qram_q : queue_t'('0);
  assign row_last    = (row_r == RW'(NUM_ROWS - 1));
  assign row_inc     = row_last ? '0 : row_r + RW'(1);
  assign alloc_row   = free_found_r ? free_r : row_r;
  assign cur         = q_r[idx_r[QW-1:0]];
  assign slot_end    = (idx_r == IW'(QUEUE_DEPTH)) || !cur.valid;
  assign q_full      = q_r[QUEUE_DEPTH-1].valid;

  // acquire: hold check, insert position and blockers
  always_comb begin
    held    = 1'b0;
    ins_pos = IW'(QUEUE_DEPTH);
    acq_blk = '0;
    for (int j = QUEUE_DEPTH - 1; j >= 0; j--) begin
      if (!q_r[j].valid) begin
        ins_pos = IW'(j);
      end
    end
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (q_r[j].valid && q_r[j].granted && q_r[j].tx == item_r.tx_id &&
          (!item_r.lock_exclusive || q_r[j].excl)) begin
        held = 1'b1;
      end
      if (IW'(j) < ins_pos && q_r[j].valid && q_r[j].granted &&
          (item_r.lock_exclusive || q_r[j].excl) && q_r[j].tx != item_r.tx_id) begin
        acq_blk[q_r[j].tx] = 1'b1;
      end
    end
    q_ins = q_r;
    if (!q_full) begin
      q_ins[ins_pos[QW-1:0]] = '{valid: 1'b1, granted: 1'b0,
                                 excl: item_r.lock_exclusive, tx: item_r.tx_id};
    end
    q_ins_g = q_ins;
    if (!q_full) begin
      q_ins_g[ins_pos[QW-1:0]].granted = 1'b1;
    end
  end

  // recheck: blockers of the current waiter
  always_comb begin
    rc_blk = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (IW'(j) < idx_r && q_r[j].valid && q_r[j].granted &&
          (cur.excl || q_r[j].excl) && q_r[j].tx != cur.tx) begin
        rc_blk[q_r[j].tx] = 1'b1;
      end
    end
  end

  // release: drop every request of the transaction, keep order
  always_comb begin
    rel_q = '0;
    kpos  = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (ram_q_eff[j].valid && ram_q_eff[j].tx != item_r.tx_id) begin
        rel_q[kpos[QW-1:0]] = ram_q_eff[j];
        kpos = kpos + IW'(1);
      end
    end
  end

  // remove the current slot
  always_comb begin
    rm_q = '0;
    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
      rm_q[j] = (IW'(j) >= idx_r) ? q_r[j+1] : q_r[j];
    end
    if (IW'(QUEUE_DEPTH - 1) < idx_r) begin
      rm_q[QUEUE_DEPTH-1] = q_r[QUEUE_DEPTH-1];
    end
  end

  // cycle search steps
  always_comb begin
    reach = cyc_s_r;
    keep  = '0;
    for (int u = 0; u < NUM_TX; u++) begin
      if (cyc_s_r[u]) begin
        reach = reach | wm_r[u];
        keep[u] = |(wm_r[u] & cyc_s_r);
      end
    end
  end

  // command decode
  always_comb begin
    q_we      = 1'b0;
    q_waddr   = row_r;
    q_wq      = q_r;
    tag_we    = 1'b0;
    emit_en   = 1'b0;
    emit_item = '{result_tx: item_r.tx_id, result_key: item_r.row_key,
                  status: cmd.code, last: 1'b0};
    cyc_start = 1'b0;
    cyc_node  = item_r.tx_id;
    case (cmd.op)
      OP_BEGIN: begin
        emit_en = 1'b1;
        emit_item.result_key = '0;
        emit_item.status     = ST_BEGUN;
      end
      OP_EMIT_IN: emit_en = 1'b1;
      OP_REL_START: begin
        emit_en = 1'b1;
        emit_item.result_key = '0;
        emit_item.status     = ST_RELEASED;
      end
      OP_LK_ALLOC: tag_we = 1'b1;
      OP_ACQ_GRANT: begin
        q_we    = 1'b1;
        q_waddr = sel_r;
        q_wq    = q_ins_g;
        emit_en = 1'b1;
        emit_item.status = ST_GRANTED;
      end
      OP_ACQ_BLOCK: cyc_start = 1'b1;
      OP_ACQ_DEAD: begin
        emit_en = 1'b1;
        emit_item.status = ST_DEADLOCK;
      end
      OP_ACQ_WAIT: begin
        q_we    = 1'b1;
        q_waddr = sel_r;
        emit_en = 1'b1;
        emit_item.status = ST_WAITING;
      end
      OP_RL_ROW: begin
        q_we = row_vld_cur;
        q_wq = rel_q;
      end
      OP_RC_END_ROW: q_we = 1'b1;
      OP_RC_GRANT: begin
        emit_en   = 1'b1;
        emit_item = '{result_tx: cur.tx, result_key: tag_r, status: ST_GRANTED, last: 1'b0};
      end
      OP_RC_BLOCK: begin
        cyc_start = 1'b1;
        cyc_node  = cur.tx;
      end
      OP_RC_DEAD: begin
        emit_en   = 1'b1;
        emit_item = '{result_tx: cur.tx, result_key: tag_r, status: ST_DEADLOCK, last: 1'b0};
      end
      default: ;
    endcase
  end

  assign out_load = (emit_en && pend_v_r) || (cmd.op == OP_FLUSH);

  rlm_ram #(.WIDTH(KEY_W), .DEPTH(NUM_ROWS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (alloc_row),
    .wdata (item_r.row_key),
    .raddr (row_r),
    .rdata (tag_q)
  );

  rlm_ram #(.WIDTH(QBITS), .DEPTH(NUM_ROWS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (QBITS'(q_wq)),
    .raddr (row_r),
    .rdata (qram_raw)
  );

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: item_r <= in_data;
      OP_LK_NEXT: begin
        if (!row_vld_cur && !free_found_r) begin
          free_r <= row_r;
        end
      end
      OP_LK_HIT: begin
        sel_r <= row_r;
        q_r   <= qram_q;
      end
      OP_LK_ALLOC: begin
        sel_r <= alloc_row;
        q_r   <= '0;
      end
      OP_ACQ_BLOCK: q_r <= q_ins;
      OP_RC_LOAD: begin
        q_r   <= qram_q;
        tag_r <= tag_q;
      end
      OP_RC_GRANT: q_r[idx_r[QW-1:0]].granted <= 1'b1;
      OP_RC_DEAD: q_r <= rm_q;
      default: ;
    endcase
    if (emit_en) begin
      pend_r <= emit_item;
    end
    if (cmd.op == OP_FLUSH) begin
      out_r <= '{result_tx: pend_r.result_tx, result_key: pend_r.result_key,
                 status: pend_r.status, last: 1'b1};
    end else if (out_load) begin
      out_r <= pend_r;
    end
    if (cyc_start) begin
      cyc_s_r <= NUM_TX'(1) << cyc_node;
    end else if (cyc_busy_r) begin
      if (!cyc_prune_r) begin
        cyc_s_r <= reach;
      end else begin
        cyc_s_r <= keep;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      free_found_r <= 1'b0;
      row_valid_r  <= '0;
      shrink_r     <= '0;
      for (int u = 0; u < NUM_TX; u++) begin
        wm_r[u] <= '0;
      end
      idx_r        <= '0;
      cnt_r        <= '0;
      pend_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
      cyc_busy_r   <= 1'b0;
      cyc_prune_r  <= 1'b0;
      cyc_done_r   <= 1'b0;
      cyc_found_r  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: cnt_r <= '0;
        OP_BEGIN: shrink_r[item_r.tx_id] <= 1'b0;
        OP_REL_START: begin
          shrink_r[item_r.tx_id] <= 1'b1;
          row_r <= '0;
        end
        OP_LK_START: begin
          row_r        <= '0;
          free_found_r <= 1'b0;
        end
        OP_LK_NEXT: begin
          if (!row_vld_cur) begin
            free_found_r <= 1'b1;
          end
          row_r <= row_inc;
        end
        OP_LK_ALLOC: row_valid_r[alloc_row] <= 1'b1;
        OP_ACQ_GRANT: wm_r[item_r.tx_id] <= '0;
        OP_ACQ_BLOCK: wm_r[item_r.tx_id] <= acq_blk;
        OP_ACQ_DEAD: wm_r[item_r.tx_id] <= '0;
        OP_RL_ROW: begin
          if (row_vld_cur) begin
            row_valid_r[row_r] <= rel_q[0].valid;
          end
          if (row_last) begin
            wm_r[item_r.tx_id] <= '0;
          end
          row_r <= row_inc;
        end
        OP_RC_LOAD: idx_r <= '0;
        OP_RC_NEXT_ROW: row_r <= row_inc;
        OP_RC_END_ROW: begin
          row_valid_r[row_r] <= q_r[0].valid;
          row_r <= row_inc;
        end
        OP_RC_GRANT: begin
          wm_r[cur.tx] <= '0;
          idx_r <= idx_r + IW'(1);
        end
        OP_RC_BLOCK: wm_r[cur.tx] <= rc_blk;
        OP_RC_SKIP: idx_r <= idx_r + IW'(1);
        OP_RC_DEAD: wm_r[cur.tx] <= '0;
        default: ;
      endcase

      if (emit_en) begin
        pend_v_r <= 1'b1;
        cnt_r    <= cnt_r + CNT_W'(1);
      end else if (cmd.op == OP_FLUSH) begin
        pend_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end

      if (cyc_start) begin
        cyc_busy_r  <= 1'b1;
        cyc_prune_r <= 1'b0;
        cyc_done_r  <= 1'b0;
      end else if (cyc_busy_r) begin
        if (!cyc_prune_r) begin
          if (reach == cyc_s_r) begin
            cyc_prune_r <= 1'b1;
          end
        end else if (keep == cyc_s_r) begin
          cyc_busy_r  <= 1'b0;
          cyc_done_r  <= 1'b1;
          cyc_found_r <= |cyc_s_r;
        end
      end
    end
  end

  assign stat = '{
    mode:         mode_t'(item_r.mode),
    shrink_hit:   shrink_r[item_r.tx_id],
    wait_hit:     |wm_r[item_r.tx_id],
    tag_hit:      row_vld_cur && (tag_q == item_r.row_key),
    row_valid:    row_vld_cur,
    row_last:     row_last,
    alloc_ok:     free_found_r || !row_vld_cur,
    held:         held,
    q_full:       q_full,
    acq_blk_zero: (acq_blk == '0),
    slot_end:     slot_end,
    slot_granted: cur.granted,
    rc_blk_zero:  (rc_blk == '0),
    cap:          (cnt_r >= CNT_W'(MAX_RESULTS)),
    cyc_busy:     cyc_busy_r,
    cyc_done:     cyc_done_r,
    cyc_found:    cyc_found_r,
    emit_ok:      !pend_v_r || !out_v_r || out_ready,
    flush_ok:     !out_v_r || out_ready
  };

  assign out_valid = out_v_r;
  assign out_data  = out_r;
endmodule

// ----- src/rlm_ctrl.sv -----
// controller: sequences acquire, release, recheck and begin over the datapath
`timescale 1ns / 1ps
module rlm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlm_pkg::dp_stat_t  stat,
  output rlm_pkg::dp_cmd_t   cmd
);
  import rlm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_LK_RD,
    S_LK_CMP,
    S_ACQ,
    S_ACQ_CYC,
    S_RL_RD,
    S_RL_ROW,
    S_RC_RD,
    S_RC_LOAD,
    S_RC_SLOT,
    S_RC_CYC,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '{op: OP_NONE, code: ST_FULL};
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.mode)
          MODE_ACQUIRE: begin
            if (stat.shrink_hit) begin
              cmd       = '{op: OP_EMIT_IN, code: ST_SHRINKING};
              state_nxt = S_FIN;
            end else if (stat.wait_hit) begin
              cmd       = '{op: OP_EMIT_IN, code: ST_FULL};
              state_nxt = S_FIN;
            end else begin
              cmd.op    = OP_LK_START;
              state_nxt = S_LK_RD;
            end
          end
          MODE_RELEASE: begin
            cmd.op    = OP_REL_START;
            state_nxt = S_RL_RD;
          end
          MODE_BEGIN: begin
            cmd.op    = OP_BEGIN;
            state_nxt = S_FIN;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_LK_RD: state_nxt = S_LK_CMP;
      S_LK_CMP: begin
        if (stat.tag_hit) begin
          cmd.op    = OP_LK_HIT;
          state_nxt = S_ACQ;
        end else if (stat.row_last) begin
          if (stat.alloc_ok) begin
            cmd.op    = OP_LK_ALLOC;
            state_nxt = S_ACQ;
          end else begin
            cmd       = '{op: OP_EMIT_IN, code: ST_FULL};
            state_nxt = S_FIN;
          end
        end else begin
          cmd.op    = OP_LK_NEXT;
          state_nxt = S_LK_RD;
        end
      end
      S_ACQ: begin
        if (stat.held) begin
          cmd       = '{op: OP_EMIT_IN, code: ST_HELD};
          state_nxt = S_FIN;
        end else if (stat.q_full) begin
          cmd       = '{op: OP_EMIT_IN, code: ST_FULL};
          state_nxt = S_FIN;
        end else if (stat.acq_blk_zero) begin
          cmd.op    = OP_ACQ_GRANT;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_ACQ_BLOCK;
          state_nxt = S_ACQ_CYC;
        end
      end
      S_ACQ_CYC: begin
        if (stat.cyc_done) begin
          cmd.op    = stat.cyc_found ? OP_ACQ_DEAD : OP_ACQ_WAIT;
          state_nxt = S_FIN;
        end
      end
      S_RL_RD: state_nxt = S_RL_ROW;
      S_RL_ROW: begin
        cmd.op    = OP_RL_ROW;
        state_nxt = stat.row_last ? S_RC_RD : S_RL_RD;
      end
      S_RC_RD: state_nxt = S_RC_LOAD;
      S_RC_LOAD: begin
        if (stat.row_valid) begin
          cmd.op    = OP_RC_LOAD;
          state_nxt = S_RC_SLOT;
        end else begin
          cmd.op    = OP_RC_NEXT_ROW;
          state_nxt = stat.row_last ? S_FIN : S_RC_RD;
        end
      end
      S_RC_SLOT: begin
        if (stat.slot_end) begin
          cmd.op    = OP_RC_END_ROW;
          state_nxt = stat.row_last ? S_FIN : S_RC_RD;
        end else if (stat.cap) begin
          cmd.op    = OP_RC_END_ROW;
          state_nxt = S_FIN;
        end else if (stat.slot_granted) begin
          cmd.op = OP_RC_SKIP;
        end else if (stat.rc_blk_zero) begin
          if (stat.emit_ok) begin
            cmd.op = OP_RC_GRANT;
          end
        end else begin
          cmd.op    = OP_RC_BLOCK;
          state_nxt = S_RC_CYC;
        end
      end
      S_RC_CYC: begin
        if (stat.cyc_done) begin
          if (!stat.cyc_found) begin
            cmd.op    = OP_RC_SKIP;
            state_nxt = S_RC_SLOT;
          end else if (stat.emit_ok) begin
            cmd.op    = OP_RC_DEAD;
            state_nxt = S_RC_SLOT;
          end
        end
      end
      S_FIN: begin
        if (stat.flush_ok) begin
          cmd.op    = OP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ----- src/row_lock_manager_deadlock_detect.sv -----
// top level: row lock manager with waits-for deadlock detection
// Input channel in_valid/in_ready/in_data carries one request transaction:
// acquire (row key, shared or exclusive), release of all locks of a
// transaction, or begin. Result channel out_valid/out_ready/out_data returns
// one or more results per request; the final one carries last. Mode 3 gives
// no result.
// One request is worked on at a time; in_ready is high only between requests.
// Acquire: a tag scan with one registered ram read per row, a queue check,
// and when blocked a waits-for cycle search.
// Release: a pass that purges the queues, then a recheck pass over the rows
// that visits each queued request of an occupied row and runs a waits-for
// search for each waiter that is still blocked.
// Results pass through a one-entry pending stage and an output register, so
// a stalled receiver only holds the block when a further result is ready.
// Synchronous reset invalidates all rows and so their queues, and clears the
// waits-for matrix and shrinking flags at once; no clearing pass is needed.
`timescale 1ns / 1ps
module row_lock_manager_deadlock_detect #(
  parameter int NUM_ROWS    = rlm_pkg::NUM_ROWS_DEF,
  parameter int QUEUE_DEPTH = rlm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rlm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rlm_pkg::out_item_t out_data
);
  import rlm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rlm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rlm_dp #(
    .NUM_ROWS    (NUM_ROWS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in progress");

  a_search_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.cyc_busy)
    else $error("cycle search still running between transactions");

  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_RELEASED || out_data.status == ST_BEGUN)
      |-> out_data.result_key == '0)
    else $error("release or begin result with non-zero key");
endmodule
